[sv/assert_macros.svh]
// Assertion helpers shared by the RTL. Clock and reset names are fixed by the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/tpmo_pkg.sv]
`default_nettype none

package tpmo_pkg;

   // Widths
   localparam int PHASE_BITS     = 32;
   localparam int SAMPLE_BITS    = 16;
   localparam int STEP_BITS      = 32;
   localparam int FRAME_BITS     = 32;
   localparam int AMP_BITS       = 16;
   localparam int MOD_INDEX_BITS = 16;
   localparam int ANGLE_BITS     = 32;
   localparam int MUL_BITS       = 32;
   localparam int PROD_BITS      = 2 * MUL_BITS;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;

   // Fixed-point shifts
   localparam int Q30_SHIFT    = 30;
   localparam int DEV_SHIFT    = 10;
   localparam int SAMPLE_SHIFT = 47 - SAMPLE_BITS;
   localparam int Q30_MAG_BITS = PROD_BITS - Q30_SHIFT;

   localparam logic [PROD_BITS-1:0] SAMPLE_MAX =
      (PROD_BITS'(1) << (SAMPLE_BITS - 1)) - PROD_BITS'(1);

   // Odd sine polynomial coefficients, Q2.30
   localparam logic signed [ANGLE_BITS-1:0] K1 = 32'sd1686629713;
   localparam logic signed [ANGLE_BITS-1:0] K3 = -32'sd693598668;
   localparam logic signed [ANGLE_BITS-1:0] K5 = 32'sd85569306;
   localparam logic signed [ANGLE_BITS-1:0] K7 = -32'sd5026995;
   localparam logic signed [ANGLE_BITS-1:0] K9 = 32'sd172272;

   // Request mode codes
   localparam logic MODE_GENERATE = 1'b0;
   localparam logic MODE_SEEK     = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CARRIER_STEP,
      CSR_MODULATOR_STEP,
      CSR_CARRIER_AMPLITUDE,
      CSR_MOD_INDEX
   } csr_index_type;

endpackage

`default_nettype wire

[sv/tpmo_req_if.sv]
`default_nettype none

interface tpmo_req_if import tpmo_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [FRAME_BITS-1:0] frame_index;

   modport source (output valid, output mode, output frame_index, input ready);
   modport sink   (input valid, input mode, input frame_index, output ready);
endinterface

`default_nettype wire

[sv/tpmo_rsp_if.sv]
`default_nettype none

interface tpmo_rsp_if import tpmo_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic [FRAME_BITS-1:0]         frame_cursor;

   modport source (output valid, output sample, output frame_cursor, input ready);
   modport sink   (input valid, input sample, input frame_cursor, output ready);
endinterface

`default_nettype wire

[sv/two_operator_phase_mod_oscillator.sv]
`default_nettype none
// Two-operator phase-modulation sine oscillator. Each generate request returns one
// signed Q1.15 sample, amplitude * sin(carrier + mod_index * sin(modulator)), tagged
// with its frame number, then advances both phase accumulators by their step words;
// a seek request sets both phases to frame_index * step and returns nothing. Sine is
// an odd degree-9 polynomial on a folded quarter wave in Q2.30. All products go
// through one registered 32x32 multiplier, each product in an issue and an absorb
// state: a generate needs 14 products, a seek needs 2. A new request is taken only
// once the last is done; a generate is done when its sample enters a free output
// register, where it waits while the next request is worked on. The user must
// write registers through the csr port only while the block is idle; the block
// itself does not enforce this.
`include "assert_macros.svh"

module two_operator_phase_mod_oscillator import tpmo_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   tpmo_req_if.sink                       req_chan,
   tpmo_rsp_if.source                     rsp_chan,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,    // operands on the multiplier
      ST_ABSORB,   // product back, fold it into the datapath
      ST_EMIT      // wait for a free output register
   } state_type;

   // Sequencer steps, one product each.
   typedef enum logic [3:0] {
      SP_Z2,       // z^2
      SP_P7,       // K7 + K9 z^2
      SP_P5,
      SP_P3,
      SP_P1,
      SP_S,        // p * z -> sine
      SP_DEV,      // mod_index * sin(modulator)
      SP_AMP,      // amplitude * sin(carrier)
      SP_SEEK_C,   // frame * carrier_step
      SP_SEEK_M    // frame * modulator_step
   } step_type;

   // Fold an angle in 2^-32 turns onto [-1/4, 1/4] turn, same sine.
   function automatic logic signed [ANGLE_BITS-1:0] fold_angle(
      input logic [ANGLE_BITS-1:0] angle
   );
      logic [ANGLE_BITS-1:0] shifted;
      shifted = angle + ANGLE_BITS'(32'h4000_0000);
      if (shifted[ANGLE_BITS-1]) begin
         return $signed(ANGLE_BITS'(32'h8000_0000) - angle);
      end
      return $signed(angle);
   endfunction

   // Top 32 bits of a phase accumulator.
   function automatic logic [ANGLE_BITS-1:0] top_angle(input logic [PHASE_BITS-1:0] phase);
      logic [PROD_BITS-1:0] wide;
      wide = PROD_BITS'(phase) << (PROD_BITS - PHASE_BITS);
      return wide[PROD_BITS-1 -: ANGLE_BITS];
   endfunction

   function automatic logic [MUL_BITS-1:0] magnitude(input logic signed [ANGLE_BITS-1:0] v);
      return v[ANGLE_BITS-1] ? MUL_BITS'(-v) : MUL_BITS'(v);
   endfunction

   // Control and configuration
   state_type                     state_ff, state_in;
   step_type                      step_ff, step_in;
   logic                          carrier_pass_ff, carrier_pass_in;
   logic [STEP_BITS-1:0]          carrier_step_ff, carrier_step_in;
   logic [STEP_BITS-1:0]          modulator_step_ff, modulator_step_in;
   logic [AMP_BITS-1:0]           carrier_amplitude_ff, carrier_amplitude_in;
   logic [MOD_INDEX_BITS-1:0]     mod_index_ff, mod_index_in;
   logic [PHASE_BITS-1:0]         carrier_phase_ff, carrier_phase_in;
   logic [PHASE_BITS-1:0]         modulator_phase_ff, modulator_phase_in;
   logic [FRAME_BITS-1:0]         frame_counter_ff, frame_counter_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Datapath
   logic [FRAME_BITS-1:0]         frame_target_ff, frame_target_in;
   logic signed [ANGLE_BITS-1:0]  z_ff, z_in;
   logic [ANGLE_BITS-1:0]         z2_ff, z2_in;
   logic signed [ANGLE_BITS-1:0]  p_ff, p_in;
   logic signed [ANGLE_BITS-1:0]  s_ff, s_in;
   logic                          neg_ff, neg_in;
   logic [SAMPLE_BITS-1:0]        sample_hold_ff, sample_hold_in;
   logic [SAMPLE_BITS-1:0]        rsp_sample_ff, rsp_sample_in;
   logic [FRAME_BITS-1:0]         rsp_frame_ff, rsp_frame_in;

   // Shared multiplier
   logic [MUL_BITS-1:0]           mul_a;
   logic [MUL_BITS-1:0]           mul_b;
   logic                          mul_neg;
   logic [PROD_BITS-1:0]          product;

   // Product post-processing
   logic [Q30_MAG_BITS-1:0]       q30_mag;
   logic signed [Q30_MAG_BITS:0]  q30_signed;
   logic signed [ANGLE_BITS-1:0]  horner_k;
   logic signed [Q30_MAG_BITS:0]  horner_sum;
   logic [PROD_BITS-1:0]          dev_rounded;
   logic [ANGLE_BITS-1:0]         dev_mag;
   logic [ANGLE_BITS-1:0]         dev_turns;
   logic [ANGLE_BITS-1:0]         carrier_angle;
   logic [PROD_BITS-1:0]          amp_rounded;
   logic [PROD_BITS-1:0]          amp_mag;
   logic [PROD_BITS-1:0]          amp_limit;
   logic [PROD_BITS-1:0]          amp_sat;
   logic [SAMPLE_BITS-1:0]        sample_value;

   logic                          req_fire;
   logic                          rsp_fire;
   logic                          out_free;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   tpmo_mul u_mul (
      .clock     (clock),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .product   (product)
   );

   // Operand select per step; the sign is tracked beside the multiplier.
   always_comb begin
      mul_a   = magnitude(p_ff);
      mul_b   = z2_ff;
      mul_neg = p_ff[ANGLE_BITS-1];
      case (step_ff)
         SP_Z2: begin
            mul_a   = magnitude(z_ff);
            mul_b   = magnitude(z_ff);
            mul_neg = 1'b0;
         end
         SP_P7: begin
            mul_a   = MUL_BITS'(K9);
            mul_b   = z2_ff;
            mul_neg = 1'b0;
         end
         SP_P5, SP_P3, SP_P1: begin
            mul_a   = magnitude(p_ff);
            mul_b   = z2_ff;
            mul_neg = p_ff[ANGLE_BITS-1];
         end
         SP_S: begin
            mul_a   = magnitude(p_ff);
            mul_b   = magnitude(z_ff);
            mul_neg = p_ff[ANGLE_BITS-1] ^ z_ff[ANGLE_BITS-1];
         end
         SP_DEV: begin
            mul_a   = magnitude(s_ff);
            mul_b   = MUL_BITS'(mod_index_ff);
            mul_neg = s_ff[ANGLE_BITS-1];
         end
         SP_AMP: begin
            mul_a   = magnitude(s_ff);
            mul_b   = MUL_BITS'(carrier_amplitude_ff);
            mul_neg = s_ff[ANGLE_BITS-1];
         end
         SP_SEEK_C: begin
            mul_a   = MUL_BITS'(frame_target_ff);
            mul_b   = MUL_BITS'(carrier_step_ff);
            mul_neg = 1'b0;
         end
         SP_SEEK_M: begin
            mul_a   = MUL_BITS'(frame_target_ff);
            mul_b   = MUL_BITS'(modulator_step_ff);
            mul_neg = 1'b0;
         end
         default: begin
            mul_neg = 1'b0;
         end
      endcase
   end

   // Q30 product, truncated toward zero, plus the Horner coefficient.
   assign q30_mag    = product[PROD_BITS-1:Q30_SHIFT];
   assign q30_signed = neg_ff ? -$signed({1'b0, q30_mag}) : $signed({1'b0, q30_mag});

   always_comb begin
      case (step_ff)
         SP_P7:   horner_k = K7;
         SP_P5:   horner_k = K5;
         SP_P3:   horner_k = K3;
         SP_P1:   horner_k = K1;
         default: horner_k = '0;
      endcase
   end

   assign horner_sum = (Q30_MAG_BITS + 1)'(horner_k) + q30_signed;

   // Deviation: round to 2^-32 turn, ties away from zero, add to carrier angle.
   assign dev_rounded   = product + (PROD_BITS'(1) << (DEV_SHIFT - 1));
   assign dev_mag       = dev_rounded[DEV_SHIFT +: ANGLE_BITS];
   assign dev_turns     = neg_ff ? -dev_mag : dev_mag;
   assign carrier_angle = top_angle(carrier_phase_ff) + dev_turns;

   // Output sample: round, then saturate on the magnitude.
   assign amp_rounded  = product + (PROD_BITS'(1) << (SAMPLE_SHIFT - 1));
   assign amp_mag      = amp_rounded >> SAMPLE_SHIFT;
   assign amp_limit    = neg_ff ? SAMPLE_MAX + PROD_BITS'(1) : SAMPLE_MAX;
   assign amp_sat      = (amp_mag > amp_limit) ? amp_limit : amp_mag;
   assign sample_value = neg_ff ? SAMPLE_BITS'(-amp_sat) : SAMPLE_BITS'(amp_sat);

   always_comb begin
      state_in             = state_ff;
      step_in              = step_ff;
      carrier_pass_in      = carrier_pass_ff;
      carrier_step_in      = carrier_step_ff;
      modulator_step_in    = modulator_step_ff;
      carrier_amplitude_in = carrier_amplitude_ff;
      mod_index_in         = mod_index_ff;
      carrier_phase_in     = carrier_phase_ff;
      modulator_phase_in   = modulator_phase_ff;
      frame_counter_in     = frame_counter_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_fire;
      frame_target_in      = frame_target_ff;
      z_in                 = z_ff;
      z2_in                = z2_ff;
      p_in                 = p_ff;
      s_in                 = s_ff;
      neg_in               = neg_ff;
      sample_hold_in       = sample_hold_ff;
      rsp_sample_in        = rsp_sample_ff;
      rsp_frame_in         = rsp_frame_ff;

      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_CARRIER_STEP:      carrier_step_in      = csr_write_data[STEP_BITS-1:0];
            CSR_MODULATOR_STEP:    modulator_step_in    = csr_write_data[STEP_BITS-1:0];
            CSR_CARRIER_AMPLITUDE: carrier_amplitude_in = csr_write_data[AMP_BITS-1:0];
            CSR_MOD_INDEX:         mod_index_in         = csr_write_data[MOD_INDEX_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               frame_target_in = req_chan.frame_index;
               carrier_pass_in = 1'b0;
               z_in            = fold_angle(top_angle(modulator_phase_ff));
               step_in         = (req_chan.mode == MODE_SEEK) ? SP_SEEK_C : SP_Z2;
               state_in        = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            neg_in   = mul_neg;
            state_in = ST_ABSORB;
         end
         ST_ABSORB: begin
            state_in = ST_ISSUE;
            case (step_ff)
               SP_Z2: begin
                  z2_in   = ANGLE_BITS'(q30_mag);
                  step_in = SP_P7;
               end
               SP_P7: begin
                  p_in    = ANGLE_BITS'(horner_sum);
                  step_in = SP_P5;
               end
               SP_P5: begin
                  p_in    = ANGLE_BITS'(horner_sum);
                  step_in = SP_P3;
               end
               SP_P3: begin
                  p_in    = ANGLE_BITS'(horner_sum);
                  step_in = SP_P1;
               end
               SP_P1: begin
                  p_in    = ANGLE_BITS'(horner_sum);
                  step_in = SP_S;
               end
               SP_S: begin
                  s_in    = ANGLE_BITS'(q30_signed);
                  step_in = carrier_pass_ff ? SP_AMP : SP_DEV;
               end
               SP_DEV: begin
                  // second sine pass on the modulated carrier angle
                  z_in            = fold_angle(carrier_angle);
                  carrier_pass_in = 1'b1;
                  step_in         = SP_Z2;
               end
               SP_AMP: begin
                  sample_hold_in = sample_value;
                  state_in       = ST_EMIT;
               end
               SP_SEEK_C: begin
                  carrier_phase_in = product[PHASE_BITS-1:0];
                  step_in          = SP_SEEK_M;
               end
               SP_SEEK_M: begin
                  modulator_phase_in = product[PHASE_BITS-1:0];
                  frame_counter_in   = frame_target_ff;
                  state_in           = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_sample_in      = sample_hold_ff;
               rsp_frame_in       = frame_counter_ff;
               rsp_valid_in       = 1'b1;
               carrier_phase_in   = carrier_phase_ff + PHASE_BITS'(carrier_step_ff);
               modulator_phase_in = modulator_phase_ff + PHASE_BITS'(modulator_step_ff);
               frame_counter_in   = frame_counter_ff + FRAME_BITS'(1);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         step_ff              <= SP_Z2;
         carrier_pass_ff      <= 1'b0;
         carrier_step_ff      <= '0;
         modulator_step_ff    <= '0;
         carrier_amplitude_ff <= '0;
         mod_index_ff         <= '0;
         carrier_phase_ff     <= '0;
         modulator_phase_ff   <= '0;
         frame_counter_ff     <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff             <= state_in;
         step_ff              <= step_in;
         carrier_pass_ff      <= carrier_pass_in;
         carrier_step_ff      <= carrier_step_in;
         modulator_step_ff    <= modulator_step_in;
         carrier_amplitude_ff <= carrier_amplitude_in;
         mod_index_ff         <= mod_index_in;
         carrier_phase_ff     <= carrier_phase_in;
         modulator_phase_ff   <= modulator_phase_in;
         frame_counter_ff     <= frame_counter_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
      frame_target_ff <= frame_target_in;
      z_ff            <= z_in;
      z2_ff           <= z2_in;
      p_ff            <= p_in;
      s_ff            <= s_in;
      neg_ff          <= neg_in;
      sample_hold_ff  <= sample_hold_in;
      rsp_sample_ff   <= rsp_sample_in;
      rsp_frame_ff    <= rsp_frame_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sample       = $signed(rsp_sample_ff);
   assign rsp_chan.frame_cursor = rsp_frame_ff;

   // A request transfer always starts the sequencer.
   `ASSERT_NEXT(a_busy_after_accept, req_fire, state_ff != ST_IDLE)
   // Deviation belongs to the modulator pass, gain to the carrier pass.
   `ASSERT_ALWAYS(a_dev_first_pass, state_ff == ST_ABSORB && step_ff == SP_DEV, !carrier_pass_ff)
   `ASSERT_ALWAYS(a_amp_second_pass, state_ff == ST_ABSORB && step_ff == SP_AMP, carrier_pass_ff)
   // A sample leaving the sequencer lands in the output register.
   `ASSERT_NEXT(a_emit_fills_slot, state_ff == ST_EMIT && out_free,
                rsp_valid_ff && state_ff == ST_IDLE)

endmodule

`default_nettype wire

[sv/tpmo_mul.sv]
`default_nettype none

// Shared unsigned multiplier, product registered.
module tpmo_mul import tpmo_pkg::*; (
   input  wire logic                 clock,
   input  wire logic [MUL_BITS-1:0]  operand_a,
   input  wire logic [MUL_BITS-1:0]  operand_b,
   output logic      [PROD_BITS-1:0] product
);

   logic [PROD_BITS-1:0] product_ff;
   logic [PROD_BITS-1:0] product_in;

   assign product_in = PROD_BITS'(operand_a) * PROD_BITS'(operand_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

[tb/oscillator_checker.sv]
`default_nettype none

module oscillator_checker import tpmo_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic                          req_mode,
   input  wire logic [FRAME_BITS-1:0]         req_frame_index,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] rsp_sample,
   input  wire logic [FRAME_BITS-1:0]         rsp_frame_cursor,
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_write_data,
   output int                                 fail_count,
   output int                                 pending_count
);

   // Odd sine polynomial, Q2.30
   localparam longint SINE_C1 = 64'sd1686629713;
   localparam longint SINE_C3 = -64'sd693598668;
   localparam longint SINE_C5 = 64'sd85569306;
   localparam longint SINE_C7 = -64'sd5026995;
   localparam longint SINE_C9 = 64'sd172272;

   localparam longint SAMPLE_HIGH = (64'sd1 << (SAMPLE_BITS - 1)) - 64'sd1;
   localparam longint SAMPLE_LOW  = -SAMPLE_HIGH - 64'sd1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [FRAME_BITS-1:0]         frame_cursor;
   } sample_record_type;

   sample_record_type expected_samples[$];

   logic [PHASE_BITS-1:0]     carrier_step;
   logic [PHASE_BITS-1:0]     modulator_step;
   logic [AMP_BITS-1:0]       amplitude;
   logic [MOD_INDEX_BITS-1:0] deviation;
   logic [PHASE_BITS-1:0]     carrier_phase;
   logic [PHASE_BITS-1:0]     modulator_phase;
   logic [FRAME_BITS-1:0]     frame_counter;

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // (a * b) >> 30, truncated toward zero
   function automatic longint q30_product(longint a, longint b);
      longint unsigned p;
      p = (magnitude(a) * magnitude(b)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   // v / 2^sh, nearest, ties away from zero
   function automatic longint round_shift(longint v, int sh);
      longint unsigned m;
      m = (magnitude(v) + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint sine_q30(logic [ANGLE_BITS-1:0] angle);
      logic [ANGLE_BITS-1:0] a;
      logic [ANGLE_BITS-1:0] lifted;
      longint z;
      longint z2;
      longint p;
      a = angle;
      lifted = a + 32'h4000_0000;
      // fold the second and third quarters back onto the first and fourth
      if (lifted[31]) a = 32'h8000_0000 - a;
      z = longint'(signed'(a));
      z2 = q30_product(z, z);
      p = SINE_C9;
      p = SINE_C7 + q30_product(p, z2);
      p = SINE_C5 + q30_product(p, z2);
      p = SINE_C3 + q30_product(p, z2);
      p = SINE_C1 + q30_product(p, z2);
      return q30_product(p, z);
   endfunction

   function automatic sample_record_type render_sample();
      sample_record_type r;
      longint inner;
      longint offset;
      longint s;
      longint v;
      logic [ANGLE_BITS-1:0] angle;
      inner = sine_q30(modulator_phase);
      offset = round_shift(inner * longint'(deviation), DEV_SHIFT);
      angle = carrier_phase + offset[ANGLE_BITS-1:0];
      s = sine_q30(angle);
      v = round_shift(s * longint'(amplitude), 47 - SAMPLE_BITS);
      if (v > SAMPLE_HIGH) v = SAMPLE_HIGH;
      if (v < SAMPLE_LOW) v = SAMPLE_LOW;
      r.sample = v[SAMPLE_BITS-1:0];
      r.frame_cursor = frame_counter;
      carrier_phase = carrier_phase + carrier_step;
      modulator_phase = modulator_phase + modulator_step;
      frame_counter = frame_counter + 1;
      return r;
   endfunction

   always @(posedge clock) begin
      sample_record_type got;
      sample_record_type want;
      if (reset) begin
         expected_samples.delete();
         carrier_step = '0;
         modulator_step = '0;
         amplitude = '0;
         deviation = '0;
         carrier_phase = '0;
         modulator_phase = '0;
         frame_counter = '0;
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.sample = rsp_sample;
            got.frame_cursor = rsp_frame_cursor;
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected result, expected none, %s %0d frame_cursor %0d",
                        $time, "actual sample", got.sample, got.frame_cursor);
               fail_count++;
            end else begin
               want = expected_samples.pop_front();
               if (got.sample !== want.sample) begin
                  $display("%0t: sample mismatch, expected %0d, actual %0d",
                           $time, want.sample, got.sample);
                  fail_count++;
               end
               if (got.frame_cursor !== want.frame_cursor) begin
                  $display("%0t: frame_cursor mismatch, expected %0d, actual %0d",
                           $time, want.frame_cursor, got.frame_cursor);
                  fail_count++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CARRIER_STEP:      carrier_step = csr_write_data[PHASE_BITS-1:0];
               CSR_MODULATOR_STEP:    modulator_step = csr_write_data[PHASE_BITS-1:0];
               CSR_CARRIER_AMPLITUDE: amplitude = csr_write_data[AMP_BITS-1:0];
               CSR_MOD_INDEX:         deviation = csr_write_data[MOD_INDEX_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_mode == MODE_SEEK) begin
               carrier_phase = req_frame_index * carrier_step;
               modulator_phase = req_frame_index * modulator_step;
               frame_counter = req_frame_index;
            end else begin
               expected_samples.push_back(render_sample());
            end
         end
      end
      pending_count = expected_samples.size();
   end

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
   import tpmo_pkg::*;

   localparam int RESET_CYCLES     = 10;
   // a trailing seek needs only its two products, so this covers it generously
   localparam int SETTLE_CYCLES    = 40;
   // long enough for the output register and the working request to fill up
   localparam int LONG_HOLD_CYCLES = 500;
   localparam int PHASES           = 8;
   localparam int PHASE_ITEMS      = 88;
   // run limit, far above the slowest legal run
   localparam int LIMIT_CYCLES     = 1_000_000;

   logic clock = 1'b0;
   logic reset;

   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   int fail_count;
   int pending_count;

   // idling controls shared between the stimulus and the result-side process
   logic sender_steady   = 1'b0;
   logic receiver_steady = 1'b0;
   logic long_hold_request = 1'b0;

   int unsigned cycle_count;

   tpmo_req_if req_chan ();
   tpmo_rsp_if rsp_chan ();

   two_operator_phase_mod_oscillator uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   oscillator_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_mode         (req_chan.mode),
      .req_frame_index  (req_chan.frame_index),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_sample       (rsp_chan.sample),
      .rsp_frame_cursor (rsp_chan.frame_cursor),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly back-to-back, some short gaps, an occasional long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 88) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 15);
      else return $urandom_range(30, 120);
   endfunction

   // Frame targets: full random range with the two ends thrown in often.
   function automatic logic [FRAME_BITS-1:0] pick_frame();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return '0;
      else if (roll == 1) return '1;
      else if (roll == 2) return FRAME_BITS'($urandom_range(1, 16));
      else return $urandom;
   endfunction

   // Register data is written full width; the upper bits of the 16-bit
   // registers must be dropped by the block.
   function automatic logic [CSR_DATA_BITS-1:0] pick_register();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      else if (roll == 1) return '1;
      else if (roll == 2) return CSR_DATA_BITS'($urandom_range(1, 255));
      else if (roll == 3) return 32'h8000_0000 | $urandom_range(0, 15);
      else return $urandom;
   endfunction

   // Result side: ready changes only at the falling edge, one assignment per step.
   // A long hold-off is counted here, independent of the stimulus.
   initial begin : result_sink
      int unsigned hold_left;
      int unsigned gap;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES - 1;
            rsp_chan.ready = 1'b0;
         end else if (receiver_steady) begin
            rsp_chan.ready = 1'b1;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               hold_left = gap - 1;
               rsp_chan.ready = 1'b0;
            end else begin
               rsp_chan.ready = 1'b1;
            end
         end
      end
   end

   // Run limit.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // One register write per cycle; caller lowers the enable afterward.
   task automatic write_csr(input csr_index_type index, input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = data;
      @(negedge clock);
   endtask

   // Only called while the block is idle.
   task automatic configure(input logic [CSR_DATA_BITS-1:0] carrier,
                            input logic [CSR_DATA_BITS-1:0] modulator,
                            input logic [CSR_DATA_BITS-1:0] gain,
                            input logic [CSR_DATA_BITS-1:0] index);
      write_csr(CSR_CARRIER_STEP, carrier);
      write_csr(CSR_MODULATOR_STEP, modulator);
      write_csr(CSR_CARRIER_AMPLITUDE, gain);
      write_csr(CSR_MOD_INDEX, index);
      csr_write_enable = 1'b0;
   endtask

   // Offer one request and hold it until the transfer. The gap after it is
   // taken here, so valid stays high straight into the next item when the gap is 0.
   task automatic send_item(input logic mode, input logic [FRAME_BITS-1:0] frame);
      int unsigned gap;
      req_chan.valid = 1'b1;
      req_chan.mode = mode;
      req_chan.frame_index = frame;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stop offering, wait for every outstanding sample, then let a trailing
   // seek finish before anything touches the registers.
   task automatic drain_results();
      req_chan.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned item;
      logic        mode;

      req_chan.valid = 1'b0;
      req_chan.mode = MODE_GENERATE;
      req_chan.frame_index = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_CARRIER_STEP;
      csr_write_data = '0;

      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Quarter-turn carrier, no modulation, full gain: walks the four sine
      // landmarks, so the positive peak hits saturation.
      configure(32'h4000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(MODE_GENERATE, 32'hFFFF_FFFF);   // frame_index ignored on generate
      send_item(MODE_GENERATE, 32'h0000_0000);
      send_item(MODE_GENERATE, 32'h1234_5678);
      send_item(MODE_GENERATE, 32'h0000_0000);
      // seek to the last frame: phase products wrap, the next generate wraps the frame counter to 0
      send_item(MODE_SEEK, 32'hFFFF_FFFF);
      send_item(MODE_GENERATE, 32'h0000_0000);
      send_item(MODE_GENERATE, 32'h0000_0000);
      send_item(MODE_SEEK, 32'h0000_0000);
      drain_results();

      // Largest carrier step, half-turn modulator step and deepest modulation.
      configure(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_8000, 32'h0000_FFFF);
      send_item(MODE_GENERATE, 32'h0000_0000);
      send_item(MODE_GENERATE, 32'hAAAA_AAAA);
      send_item(MODE_GENERATE, 32'h5555_5555);
      send_item(MODE_GENERATE, 32'h0000_0000);
      send_item(MODE_SEEK, 32'h8000_0001);
      send_item(MODE_GENERATE, 32'h0000_0000);
      send_item(MODE_GENERATE, 32'h0000_0000);
      send_item(MODE_SEEK, 32'h5555_5555);
      send_item(MODE_GENERATE, 32'h0000_0000);
      send_item(MODE_GENERATE, 32'h0000_0000);
      drain_results();

      // Everything at zero: silent output, frame cursor still counts.
      configure(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_item(MODE_GENERATE, 32'hAAAA_AAAA);
      send_item(MODE_GENERATE, 32'h5555_5555);
      send_item(MODE_SEEK, 32'h0000_0001);

      for (phase = 0; phase < PHASES; phase++) begin
         drain_results();
         sender_steady = (phase % 4 == 3);
         receiver_steady = (phase % 4 == 2) || (phase % 4 == 3);
         if (phase == 6)
            configure(32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF, 32'h0000_FFFF);
         else if (phase == 7)
            configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
         else
            configure(pick_register(), pick_register(), pick_register(), pick_register());
         // backpressure: result side stalls long while requests keep coming
         if (phase == 1) long_hold_request = 1'b1;
         for (item = 0; item < PHASE_ITEMS; item++) begin
            mode = ($urandom_range(0, 99) < 15) ? MODE_SEEK : MODE_GENERATE;
            send_item(mode, pick_frame());
         end
      end

      drain_results();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
